// ===== rtl/keyword_outside_literals_finder_defines.svh =====
`ifndef KEYWORD_OUTSIDE_LITERALS_FINDER_DEFINES_SVH
`define KEYWORD_OUTSIDE_LITERALS_FINDER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KOLF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KOLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kolf_pkg.sv =====
`timescale 1ns / 1ps

package kolf_pkg;

	// Sizes of the keyword, the byte window and the counters.
	localparam int KW_MAX     = 8;
	localparam int WIN_DEPTH  = KW_MAX + 2;
	localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
	localparam int LEN_W      = $clog2(KW_MAX + 1);
	localparam int POS_BITS   = 16;
	localparam int DEPTH_BITS = 16;

	// Configuration port.
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_CHARS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL_ONLY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 2'd3;

	// Eligibility marks that the lexer raises for the two newest window slots.
	typedef struct packed {
		logic mark0;
		logic mark1;
	} marks_t;

	// Comparison results of one cell on the byte entering it.
	typedef struct packed {
		logic eq_a;
		logic eq_b;
		logic ident;
	} cmp_t;

endpackage

// ===== rtl/kolf_cell.sv =====
`timescale 1ns / 1ps

module kolf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            clear,
	input  logic [7:0]      d_byte,
	input  logic            d_elig,
	input  logic [7:0]      kw_a,
	input  logic [7:0]      kw_b,
	output logic [7:0]      q_byte,
	output logic            q_elig,
	output kolf_pkg::cmp_t  cmp
);
	import kolf_pkg::*;

	logic [7:0] byte_q;
	logic       elig_q;
	logic [7:0] up_d;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
	endfunction

	// Compare the incoming byte against both keyword alignments.
	always_comb begin
		up_d      = to_upper(d_byte);
		cmp.eq_a  = (up_d == to_upper(kw_a));
		cmp.eq_b  = (up_d == to_upper(kw_b));
		cmp.ident = is_ident(d_byte);
	end

	// Window slot: loads its input on every accepted byte but the final one, which clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			elig_q <= 1'b0;
		end else if (clear) begin
			byte_q <= '0;
			elig_q <= 1'b0;
		end else if (shift) begin
			byte_q <= d_byte;
			elig_q <= d_elig;
		end
	end

	assign q_byte = byte_q;
	assign q_elig = elig_q;

endmodule

// ===== rtl/kolf_lexer.sv =====
`timescale 1ns / 1ps

module kolf_lexer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      active,
	input  logic                      ok,
	input  logic                      last,
	input  logic                      top_only,
	input  logic [7:0]                ch,
	output kolf_pkg::marks_t          marks
);
	import kolf_pkg::*;

	localparam logic [3:0] M_CODE       = 4'd0;
	localparam logic [3:0] M_SQ         = 4'd1;
	localparam logic [3:0] M_SQ_Q       = 4'd2;
	localparam logic [3:0] M_DQ         = 4'd3;
	localparam logic [3:0] M_DQ_Q       = 4'd4;
	localparam logic [3:0] M_BRACKET    = 4'd5;
	localparam logic [3:0] M_SLASH      = 4'd6;
	localparam logic [3:0] M_DASH       = 4'd7;
	localparam logic [3:0] M_LINE       = 4'd8;
	localparam logic [3:0] M_BLOCK      = 4'd9;
	localparam logic [3:0] M_BLOCK_STAR = 4'd10;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	logic [3:0]            mode_q, mode_n;
	logic [DEPTH_BITS-1:0] depth_q, depth_n;
	logic                  pend_q, pend_n;
	logic                  do_code;
	logic                  depth_ok;

	assign depth_ok = !top_only || (depth_q == '0);

	// Next lexer state and eligibility marks for the byte on the input.
	always_comb begin
		mode_n      = mode_q;
		depth_n     = depth_q;
		pend_n      = pend_q;
		do_code     = 1'b0;
		marks.mark0 = 1'b0;
		marks.mark1 = 1'b0;
		if (active) begin
			unique case (mode_q)
				M_SQ: begin
					if (ch == CH_SQUOTE) mode_n = M_SQ_Q;
				end
				M_SQ_Q: begin
					if (ch == CH_SQUOTE) mode_n = M_SQ;
					else do_code = 1'b1;
				end
				M_DQ: begin
					if (ch == CH_DQUOTE) mode_n = M_DQ_Q;
				end
				M_DQ_Q: begin
					if (ch == CH_DQUOTE) mode_n = M_DQ;
					else do_code = 1'b1;
				end
				M_BRACKET: begin
					if (ch == CH_RBRACK) mode_n = M_CODE;
				end
				M_SLASH: begin
					if (ch == CH_SLASH) mode_n = M_LINE;
					else if (ch == CH_STAR) mode_n = M_BLOCK;
					else begin
						marks.mark1 = pend_q && depth_ok;
						do_code     = 1'b1;
					end
				end
				M_DASH: begin
					if (ch == CH_DASH) mode_n = M_LINE;
					else begin
						marks.mark1 = pend_q && depth_ok;
						do_code     = 1'b1;
					end
				end
				M_LINE: begin
					if (ch == CH_NL) mode_n = M_CODE;
				end
				M_BLOCK: begin
					if (ch == CH_STAR) mode_n = M_BLOCK_STAR;
				end
				M_BLOCK_STAR: begin
					if (ch == CH_SLASH) mode_n = M_CODE;
					else if (ch != CH_STAR) mode_n = M_BLOCK;
				end
				default: begin
					do_code = 1'b1;
				end
			endcase
		end

		// A byte seen in plain code.
		if (do_code) begin
			mode_n = M_CODE;
			if (ch == CH_SQUOTE) mode_n = M_SQ;
			else if (ch == CH_DQUOTE) mode_n = M_DQ;
			else if (ch == CH_LBRACK) mode_n = M_BRACKET;
			else if (ch == CH_SLASH) begin
				mode_n = M_SLASH;
				pend_n = ok;
			end else if (ch == CH_DASH) begin
				mode_n = M_DASH;
				pend_n = ok;
			end else if (ch == CH_LPAREN) begin
				if (depth_q != DEPTH_MAX) depth_n = depth_q + 1'b1;
			end else if (ch == CH_RPAREN && depth_q != '0) begin
				depth_n = depth_q - 1'b1;
			end else begin
				marks.mark0 = ok && depth_ok;
			end
		end

		// A slash or dash on the final byte is an ordinary code byte.
		if (last && (mode_n == M_SLASH || mode_n == M_DASH)) begin
			marks.mark0 = marks.mark0 ||
				(pend_n && (!top_only || depth_n == '0));
		end
	end

	// Lexer state; returns to plain code after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_CODE;
			depth_q <= '0;
			pend_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				mode_q  <= M_CODE;
				depth_q <= '0;
				pend_q  <= 1'b0;
			end else begin
				mode_q  <= mode_n;
				depth_q <= depth_n;
				pend_q  <= pend_n;
			end
		end
	end

endmodule

// ===== rtl/keyword_outside_literals_finder.sv =====
`timescale 1ns / 1ps
`include "keyword_outside_literals_finder_defines.svh"

// Channel   Handshake              Payload
// input     in_valid / in_ready    char_byte, last_byte
// result    out_valid / out_ready  found, match_position
// config    cfg_we                 cfg_index, cfg_data
//
// One byte is taken per cycle unless the input is stalled; the lexer step and the
// keyword compare in the row of window cells both complete in the cycle the byte is accepted.
// The result appears in the output register in the cycle after the final byte is accepted.
// Reset clears the lexer, the window and the counters; configuration registers
// return to keyword length eight, all other fields zero.
// Input is stalled only while a result waits in the output register and the
// result side is not ready.

module keyword_outside_literals_finder (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [7:0]                             char_byte,
	input  logic                                   last_byte,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	output logic                                   found,
	output logic [kolf_pkg::POS_BITS-1:0]          match_position,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   cfg_we,
	input  logic [kolf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kolf_pkg::CFG_W-1:0]             cfg_data
);
	import kolf_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// Configuration registers.
	logic [8*KW_MAX-1:0] kw_q;
	logic [3:0]          len_q;
	logic                top_q;
	logic [15:0]         start_q;

	// Statement state.
	logic [POS_BITS-1:0] byte_idx_q;
	logic                seen_q;
	logic [POS_BITS-1:0] first_q;

	// Output register.
	logic                out_valid_q;
	logic                found_q;
	logic [POS_BITS-1:0] pos_q;

	logic                accept;
	logic                active;
	logic                ok;
	marks_t              marks;
	logic [LEN_W-1:0]    len_eff;
	logic [WIN_IDX_W-1:0] li, li_p1, li_m1;

	logic [7:0]           al [WIN_DEPTH+1];
	logic [7:0]           d_byte [WIN_DEPTH];
	logic [7:0]           win_byte [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] d_elig;
	logic [WIN_DEPTH-1:0] win_elig;
	cmp_t                 cmp [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] eq_a_v, eq_b_v, ident_v;

	logic                 ok_a, ok_b, hit_a, hit_b, seen_n;
	logic [POS_BITS-1:0]  first_n;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q    <= '0;
			len_q   <= 4'd8;
			top_q   <= 1'b0;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEYWORD_CHARS:  kw_q    <= cfg_data[8*KW_MAX-1:0];
				CFG_KEYWORD_LENGTH: len_q   <= cfg_data[3:0];
				CFG_TOP_LEVEL_ONLY: top_q   <= cfg_data[0];
				CFG_START_OFFSET:   start_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Keyword length in use, and window indexes derived from it.
	always_comb begin
		if (len_q == 4'd0) len_eff = LEN_W'(1);
		else if (int'(len_q) > KW_MAX) len_eff = LEN_W'(KW_MAX);
		else len_eff = LEN_W'(len_q);
		li    = WIN_IDX_W'(len_eff);
		li_p1 = WIN_IDX_W'(int'(len_eff) + 1);
		li_m1 = WIN_IDX_W'(int'(len_eff) - 1);
	end

	// Keyword bytes aligned to window slots: slot j holds keyword byte len-j.
	always_comb begin
		for (int j = 0; j <= WIN_DEPTH; j++) begin
			al[j] = '0;
			if (j >= 1 && j <= int'(len_eff)) begin
				al[j] = kw_q[8*(int'(len_eff) - j) +: 8];
			end
		end
	end

	assign active = 32'(byte_idx_q) >= 32'(start_q);
	assign ok     = (({1'b0, byte_idx_q}) + (POS_BITS+1)'(KW_MAX)) <
		{1'b0, POS_MAX};

	kolf_lexer u_lexer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (accept),
		.active         (active),
		.ok             (ok),
		.last           (last_byte),
		.top_only       (top_q),
		.ch             (char_byte),
		.marks          (marks)
	);

	// Data entering each window cell.
	always_comb begin
		d_byte[0] = char_byte;
		d_elig[0] = marks.mark0;
		for (int j = 1; j < WIN_DEPTH; j++) begin
			d_byte[j] = win_byte[j-1];
			d_elig[j] = win_elig[j-1];
		end
		d_elig[1] = win_elig[0] || marks.mark1;
	end

	// Row of window cells.
	for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
		kolf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (accept),
			.clear  (accept && last_byte),
			.d_byte (d_byte[g]),
			.d_elig (d_elig[g]),
			.kw_a   (al[g]),
			.kw_b   (al[g+1]),
			.q_byte (win_byte[g]),
			.q_elig (win_elig[g]),
			.cmp    (cmp[g])
		);
		assign eq_a_v[g]  = cmp[g].eq_a;
		assign eq_b_v[g]  = cmp[g].eq_b;
		assign ident_v[g] = cmp[g].ident;
	end

	// Keyword match: ending one byte back with a boundary after, or ending on
	// the final byte of the statement.
	always_comb begin
		ok_a = 1'b1;
		ok_b = 1'b1;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			if (j >= 1 && j <= int'(len_eff)) ok_a = ok_a && eq_a_v[j];
			if (j <= int'(len_eff) - 1) ok_b = ok_b && eq_b_v[j];
		end
		hit_a = !seen_q && d_elig[li] && ok_a && !ident_v[li_p1] && !ident_v[0];
		hit_b = last_byte && !seen_q && !hit_a && d_elig[li_m1] && ok_b &&
			!ident_v[li];
		seen_n  = seen_q || hit_a || hit_b;
		first_n = first_q;
		if (hit_a) first_n = byte_idx_q - POS_BITS'(len_eff);
		else if (hit_b) first_n = byte_idx_q - POS_BITS'(int'(len_eff) - 1);
	end

	// Statement state; cleared after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= '0;
			seen_q     <= 1'b0;
			first_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				byte_idx_q <= '0;
				seen_q     <= 1'b0;
				first_q    <= '0;
			end else begin
				seen_q  <= seen_n;
				first_q <= first_n;
				if (byte_idx_q != POS_MAX) byte_idx_q <= byte_idx_q + 1'b1;
			end
		end
	end

	// Output register, loaded on the final byte of a statement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			found_q <= seen_n;
			pos_q   <= seen_n ? first_n : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;

	// Checks on the block's own logic.
	`KOLF_ASSERT_NOW(a_pos_zero_when_absent, out_valid && !found, match_position == '0, "position set without a match")
	`KOLF_ASSERT_NEXT(a_result_after_last, accept && last_byte, out_valid, "no result after the final byte")
	`KOLF_ASSERT_NEXT(a_index_restart, accept && last_byte, byte_idx_q == '0 && !seen_q, "statement state not cleared")
	`KOLF_ASSERT_NOW(a_first_clear, !seen_q, first_q == '0, "match index set without a match")

endmodule

// ===== sim/keyword_outside_literals_finder_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, result and config channels of the finder, keeps its own copy of the
// registers and the lexer state, and compares every result transaction with the
// oldest predicted one.
module keyword_outside_literals_finder_checker
	import kolf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           char_byte,
	input  logic                 last_byte,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 found,
	input  logic [POS_BITS-1:0]  match_position,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending_results,
	output int                   checked_results,
	output int                   hit_results
);

	localparam int POS_TOP   = (1 << POS_BITS) - 1;

	localparam logic [7:0] CH_SQUOTE   = "'";
	localparam logic [7:0] CH_DQUOTE   = "\"";
	localparam logic [7:0] CH_LBRACKET = "[";
	localparam logic [7:0] CH_RBRACKET = "]";
	localparam logic [7:0] CH_LPAREN   = "(";
	localparam logic [7:0] CH_RPAREN   = ")";
	localparam logic [7:0] CH_SLASH    = "/";
	localparam logic [7:0] CH_DASH     = "-";
	localparam logic [7:0] CH_STAR     = "*";
	localparam logic [7:0] CH_UNDER    = "_";
	localparam logic [7:0] CH_NL       = "\n";

	typedef enum logic [3:0] {
		LX_CODE, LX_SQ, LX_SQ_Q, LX_DQ, LX_DQ_Q, LX_BRACKET,
		LX_SLASH, LX_DASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR
	} scan_mode_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
	} verdict_t;

	// Register copies.
	logic [CFG_W-1:0] kw_bytes;
	logic [3:0]       kw_len_reg;
	logic             top_only;
	logic [15:0]      lex_start;

	// Scanner state.
	scan_mode_t            scan_mode;
	logic [DEPTH_BITS-1:0] nest_level;
	logic [7:0]            byte_win [WIN_DEPTH];
	logic                  elig_win [WIN_DEPTH];
	logic [POS_BITS-1:0]   scan_index;
	logic                  hit_seen;
	logic [POS_BITS-1:0]   hit_index;
	logic                  pend_ok;

	verdict_t expected_verdicts [$];
	int       mismatches;
	int       results_seen;
	int       hits_seen;

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == CH_UNDER;
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// A length of zero acts as one, anything above the maximum as the maximum.
	function automatic int used_length();
		if (kw_len_reg == 0) return 1;
		if (kw_len_reg > KW_MAX) return KW_MAX;
		return int'(kw_len_reg);
	endfunction

	function automatic logic window_matches(input int k, input int len, input logic check_after);
		logic [7:0] kb;
		if (k + 1 >= WIN_DEPTH || len > k + 1) return 1'b0;
		for (int i = 0; i < len; i++) begin
			kb = kw_bytes[8*i +: 8];
			if (to_upper(byte_win[k - i]) != to_upper(kb)) return 1'b0;
		end
		if (is_ident(byte_win[k + 1])) return 1'b0;
		if (check_after && is_ident(byte_win[0])) return 1'b0;
		return 1'b1;
	endfunction

	task automatic clear_scan();
		scan_mode  = LX_CODE;
		nest_level = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			byte_win[i] = '0;
			elig_win[i] = 1'b0;
		end
		scan_index = '0;
		hit_seen   = 1'b0;
		hit_index  = '0;
		pend_ok    = 1'b0;
	endtask

	task automatic mark_slot(input int k, input logic ok);
		if (ok && (!top_only || nest_level == 0) && k < WIN_DEPTH) elig_win[k] = 1'b1;
	endtask

	// A byte seen in plain code: opens a literal, defers a possible comment
	// opener, tracks parentheses, or becomes a candidate keyword byte.
	task automatic take_code_byte(input logic [7:0] c, input logic ok);
		case (c)
			CH_SQUOTE: scan_mode = LX_SQ;
			CH_DQUOTE: scan_mode = LX_DQ;
			CH_LBRACKET: scan_mode = LX_BRACKET;
			CH_SLASH: begin
				scan_mode = LX_SLASH;
				pend_ok   = ok;
			end
			CH_DASH: begin
				scan_mode = LX_DASH;
				pend_ok   = ok;
			end
			CH_LPAREN: begin
				if (nest_level != '1) nest_level++;
			end
			CH_RPAREN: begin
				if (nest_level != 0) nest_level--;
				else mark_slot(0, ok);
			end
			default: mark_slot(0, ok);
		endcase
	endtask

	task automatic lex_byte(input logic [7:0] c, input logic ok);
		case (scan_mode)
			LX_SQ: begin
				if (c == CH_SQUOTE) scan_mode = LX_SQ_Q;
			end
			LX_SQ_Q: begin
				if (c == CH_SQUOTE) scan_mode = LX_SQ;
				else begin
					scan_mode = LX_CODE;
					take_code_byte(c, ok);
				end
			end
			LX_DQ: begin
				if (c == CH_DQUOTE) scan_mode = LX_DQ_Q;
			end
			LX_DQ_Q: begin
				if (c == CH_DQUOTE) scan_mode = LX_DQ;
				else begin
					scan_mode = LX_CODE;
					take_code_byte(c, ok);
				end
			end
			LX_BRACKET: begin
				if (c == CH_RBRACKET) scan_mode = LX_CODE;
			end
			LX_SLASH: begin
				if (c == CH_SLASH) scan_mode = LX_LINE;
				else if (c == CH_STAR) scan_mode = LX_BLOCK;
				else begin
					mark_slot(1, pend_ok);
					scan_mode = LX_CODE;
					take_code_byte(c, ok);
				end
			end
			LX_DASH: begin
				if (c == CH_DASH) scan_mode = LX_LINE;
				else begin
					mark_slot(1, pend_ok);
					scan_mode = LX_CODE;
					take_code_byte(c, ok);
				end
			end
			LX_LINE: begin
				if (c == CH_NL) scan_mode = LX_CODE;
			end
			LX_BLOCK: begin
				if (c == CH_STAR) scan_mode = LX_BLOCK_STAR;
			end
			LX_BLOCK_STAR: begin
				if (c == CH_SLASH) scan_mode = LX_CODE;
				else if (c != CH_STAR) scan_mode = LX_BLOCK;
			end
			default: begin
				scan_mode = LX_CODE;
				take_code_byte(c, ok);
			end
		endcase
	endtask

	// Advances the scanner by one byte and, on the final byte of a statement,
	// queues the result the finder has to give.
	task automatic scan_byte(input logic [7:0] c, input logic is_last);
		logic [POS_BITS-1:0] pos;
		int                  len;
		verdict_t            want;
		pos = scan_index;
		len = used_length();
		for (int i = WIN_DEPTH - 1; i > 0; i--) begin
			byte_win[i] = byte_win[i-1];
			elig_win[i] = elig_win[i-1];
		end
		byte_win[0] = c;
		elig_win[0] = 1'b0;
		if (pos >= lex_start) lex_byte(c, int'(pos) + KW_MAX < POS_TOP);
		if (is_last && (scan_mode == LX_SLASH || scan_mode == LX_DASH)) mark_slot(0, pend_ok);
		if (!hit_seen && elig_win[len] && window_matches(len, len, 1'b1)) begin
			hit_seen  = 1'b1;
			hit_index = pos - POS_BITS'(len);
		end
		if (is_last && !hit_seen && elig_win[len-1] && window_matches(len - 1, len, 1'b0)) begin
			hit_seen  = 1'b1;
			hit_index = pos - POS_BITS'(len - 1);
		end
		if (scan_index != '1) scan_index++;
		if (is_last) begin
			want.found    = hit_seen;
			want.position = hit_seen ? hit_index : '0;
			expected_verdicts.push_back(want);
			clear_scan();
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Results are checked before the byte of the same edge is scanned, since a result
	// leaves the finder no earlier than the cycle after its final byte.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			kw_bytes   = '0;
			kw_len_reg = 4'd8;
			top_only   = 1'b0;
			lex_start  = '0;
			clear_scan();
			expected_verdicts.delete();
			mismatches   = 0;
			results_seen = 0;
			hits_seen    = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (found) hits_seen++;
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%0b position=%0d",
						found, match_position));
				end else begin
					want = expected_verdicts.pop_front();
					if (found !== want.found)
						report_mismatch($sformatf("found is %0b, predicted %0b",
							found, want.found));
					if (match_position !== want.position)
						report_mismatch($sformatf("match_position is %0d, predicted %0d",
							match_position, want.position));
				end
			end
			if (in_valid && in_ready) scan_byte(char_byte, last_byte);
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEYWORD_CHARS: kw_bytes = cfg_data;
					CFG_KEYWORD_LENGTH: kw_len_reg = cfg_data[3:0];
					CFG_TOP_LEVEL_ONLY: top_only = cfg_data[0];
					CFG_START_OFFSET: lex_start = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		fail_count      <= mismatches;
		pending_results <= expected_verdicts.size();
		checked_results <= results_seen;
		hit_results     <= hits_seen;
	end

endmodule

// ===== sim/keyword_outside_literals_finder_test.sv =====
`timescale 1ns / 1ps

// Drives statements into the finder under changing registers and idling
// patterns; the checker beside the block predicts and compares.
module keyword_outside_literals_finder_test;
	import kolf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_BYTES   = 45;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [7:0]           char_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 found;
	logic [POS_BITS-1:0]  match_position;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_KEYWORD_CHARS;
	logic [CFG_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending_results;
	int checked_results;
	int hit_results;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;
	int statements_sent = 0;
	int settings_loaded = 0;

	logic [63:0] kw_now;
	logic [3:0]  len_now;
	logic [7:0]  stmt_bytes [$];

	keyword_outside_literals_finder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_byte      (char_byte),
		.last_byte      (last_byte),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.found          (found),
		.match_position (match_position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	keyword_outside_literals_finder_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_byte       (char_byte),
		.last_byte       (last_byte),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.found           (found),
		.match_position  (match_position),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.checked_results (checked_results),
		.hit_results     (hit_results)
	);

	always #2 clk = ~clk;

	// The result side stalls at random according to the current idling pattern.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// A long stretch without any transaction ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("keyword_outside_literals_finder_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int kw_span(input logic [3:0] len);
		if (len == 0) return 1;
		if (len > KW_MAX) return KW_MAX;
		return int'(len);
	endfunction

	function automatic logic [7:0] random_ident_char();
		case ($urandom_range(3))
			0: return 8'($urandom_range("Z", "A"));
			1: return 8'($urandom_range("z", "a"));
			2: return 8'($urandom_range("9", "0"));
			default: return "_";
		endcase
	endfunction

	// Keyword of identifier characters with a letter in front.
	function automatic logic [63:0] random_keyword();
		logic [63:0] kw;
		kw[7:0] = $urandom_range(1) ? 8'($urandom_range("Z", "A")) : 8'($urandom_range("z", "a"));
		for (int i = 1; i < 8; i++) kw[8*i +: 8] = random_ident_char();
		return kw;
	endfunction

	task automatic set_idling(input idling_t pattern);
		case (pattern)
			IDLE_SENDER: begin
				send_gap_pct   = 68;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_gap_pct   = 0;
				recv_stall_pct = 68;
			end
			IDLE_BOTH: begin
				send_gap_pct   = 13;
				recv_stall_pct = 13;
			end
			default: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Writes all four registers on consecutive edges; only called while idle.
	task automatic load_config(input logic [63:0] kw, input logic [3:0] len, input logic top,
		input logic [15:0] off);
		kw_now  = kw;
		len_now = len;
		settings_loaded++;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEYWORD_CHARS;
		cfg_data  <= kw;
		@(posedge clk);
		cfg_index <= CFG_KEYWORD_LENGTH;
		cfg_data  <= CFG_W'(len);
		@(posedge clk);
		cfg_index <= CFG_TOP_LEVEL_ONLY;
		cfg_data  <= CFG_W'(top);
		@(posedge clk);
		cfg_index <= CFG_START_OFFSET;
		cfg_data  <= CFG_W'(off);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] c, input logic lst);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid  <= 1'b1;
		char_byte <= c;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_statement();
		for (int i = 0; i < stmt_bytes.size(); i++)
			send_byte(stmt_bytes[i], i == stmt_bytes.size() - 1);
		statements_sent++;
	endtask

	// Holds the sender off until every predicted result has been taken.
	task automatic await_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) stmt_bytes.push_back(s[i]);
	endtask

	task automatic run_text(input string s);
		stmt_bytes.delete();
		push_text(s);
		send_statement();
	endtask

	// The configured keyword with letters in random case.
	task automatic push_keyword();
		logic [7:0] b;
		for (int i = 0; i < kw_span(len_now); i++) begin
			b = kw_now[8*i +: 8];
			if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(1)) b = b ^ 8'h20;
			stmt_bytes.push_back(b);
		end
	endtask

	task automatic push_ident();
		repeat ($urandom_range(4, 1)) stmt_bytes.push_back(random_ident_char());
	endtask

	// Filling for literals and comments; it may hold the keyword itself.
	task automatic push_filling(input string doubled);
		repeat ($urandom_range(3)) begin
			case ($urandom_range(4))
				0, 1: push_keyword();
				2: push_ident();
				3: push_text(doubled);
				default: push_text(" ");
			endcase
		end
	endtask

	task automatic add_token();
		case ($urandom_range(12))
			0, 1: push_keyword();
			2: begin
				if ($urandom_range(1)) begin
					push_ident();
					push_keyword();
				end else begin
					push_keyword();
					push_ident();
				end
			end
			3: push_ident();
			4: begin
				push_text("'");
				push_filling("''");
				if ($urandom_range(7) != 0) push_text("'");
			end
			5: begin
				push_text("\"");
				push_filling("\"\"");
				if ($urandom_range(7) != 0) push_text("\"");
			end
			6: begin
				push_text("[");
				push_filling(" ");
				if ($urandom_range(7) != 0) push_text("]");
			end
			7: begin
				push_text($urandom_range(1) ? "//" : "--");
				push_filling("'");
				if ($urandom_range(7) != 0) push_text("\n");
			end
			8: begin
				push_text($urandom_range(2) == 0 ? "/*/" : "/*");
				push_filling("*");
				if ($urandom_range(7) != 0) push_text($urandom_range(1) ? "**/" : "*/");
			end
			9: push_text($urandom_range(2) == 0 ? ")" : "(");
			10: begin
				case ($urandom_range(4))
					0: push_text("/");
					1: push_text("-");
					2: push_text("*");
					3: push_text("=");
					default: push_text(",");
				endcase
			end
			11: stmt_bytes.push_back(8'($urandom_range(255)));
			default: begin
				// A cut-off keyword that must not match.
				for (int i = 0; i < kw_span(len_now) - 1; i++) stmt_bytes.push_back(kw_now[8*i +: 8]);
				if (kw_span(len_now) == 1) push_ident();
			end
		endcase
		if ($urandom_range(1)) begin
			case ($urandom_range(3))
				0: push_text("\n");
				1: push_text("\t");
				default: push_text(" ");
			endcase
		end
	endtask

	task automatic run_random_phase(input idling_t pattern, input logic [63:0] kw,
		input logic [3:0] len, input logic top, input logic [15:0] off);
		int phase_bytes;
		int phase_stmts;
		load_config(kw, len, top, off);
		set_idling(pattern);
		phase_bytes = 0;
		phase_stmts = 0;
		while (phase_bytes < RANDOM_BYTES || phase_stmts < 3) begin
			stmt_bytes.delete();
			repeat ($urandom_range(6, 1)) add_token();
			phase_bytes += stmt_bytes.size();
			send_statement();
			phase_stmts++;
			if (phase_stmts == 3) await_drain();
		end
		await_drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed statements with the keyword "AB", unused bytes all ones.
		load_config(64'hFFFF_FFFF_FFFF_4241, 4'd2, 1'b0, 16'd0);
		run_text("ab");
		run_text("x)ab(");
		run_text("'a''ab'ab");
		run_text("/ab-ab/");
		run_text("--ab\nab-");
		run_text("/*/ab*/ab");
		run_text("[ab]\"a\"\"b\"aB_ AB");
		run_text("'ab");
		await_drain();

		// Top level only, lexing from the third byte.
		load_config(64'hFFFF_FFFF_FFFF_4241, 4'd2, 1'b1, 16'd2);
		run_text("(ab)ab");
		run_text("ab ab");
		stmt_bytes.delete();
		push_text("x");
		stmt_bytes.push_back(8'hFF);
		push_text("ab");
		send_statement();
		await_drain();

		// Random statements under a range of settings and idling patterns.
		run_random_phase(IDLE_NONE, random_keyword(), 4'd1, 1'b0, 16'd0);
		run_random_phase(IDLE_SENDER, random_keyword(), 4'd8, 1'b1, 16'd0);
		run_random_phase(IDLE_RECEIVER, random_keyword(), 4'($urandom_range(8, 1)),
			1'($urandom_range(1)), 16'($urandom_range(6)));
		run_random_phase(IDLE_BOTH, random_keyword(), 4'd0, 1'b0, 16'($urandom_range(3)));
		run_random_phase(IDLE_NONE, random_keyword(), 4'd15, 1'b1, 16'd0);
		run_random_phase(IDLE_SENDER, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 16'd0);
		run_random_phase(IDLE_RECEIVER, 64'h0, 4'($urandom_range(8, 1)), 1'b1, 16'd0);
		run_random_phase(IDLE_BOTH, random_keyword(), 4'($urandom_range(8, 1)), 1'b0, 16'hFFFF);
		run_random_phase(IDLE_BOTH, random_keyword(), 4'($urandom_range(8, 1)),
			1'($urandom_range(1)), 16'($urandom_range(4)));

		$display("Covered %0d statements (%0d bytes) under %0d register settings and four idling",
			statements_sent, bytes_sent, settings_loaded);
		$display("patterns; %0d results checked, %0d of them with a match.",
			checked_results, hit_results);
		if (fail_count == 0) begin
			$display("keyword_outside_literals_finder_test passed");
		end else begin
			$display("keyword_outside_literals_finder_test failed");
		end
		$finish;
	end

endmodule
